[hw/rtl/ssr_pkg.sv]
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants and types of the hashed residual refiner.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int TBL_BITS_DEF     = 12;
   localparam int FAMILY_COUNT_DEF = 10;
   localparam int MAX_FAMILIES     = 10;

   localparam int PROB_W    = 16;
   localparam int INDEX_W   = 12;
   localparam int COUNT_W   = 32;
   localparam int SUM_W     = 64;
   localparam int USED_W    = 4;
   localparam int PRIOR_W   = 16;
   localparam int STRENGTH_W = 20;
   localparam int MASK_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 20;
   localparam int ACC_W     = 70;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_PRIOR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK     = 2'd2;

   localparam logic [PRIOR_W-1:0]    PRIOR_RESET    = 16'd256;
   localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 20'd250000;
   localparam logic [MASK_W-1:0]     MASK_RESET     = 10'd255;

   localparam logic [STRENGTH_W-1:0] PPM_SCALE = 20'd1000000;
   localparam logic [16:0]           PROB_ONE  = 17'd65536;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
   } ssr_lane_ctl_type;

endpackage

[hw/rtl/hashed_residual_sse_refiner.sv]
// ----------------------------------------------------------------------------
// hashed_residual_sse_refiner
// Secondary estimation of a bit probability from hashed residual tables.
// ----------------------------------------------------------------------------
// Usage: a word on req_ carries the base probability, the coded bit and one
// table index per hash family; each word yields exactly one word on rsp_
// with the refined probability and the number of contributing families.
// The csr_ port writes prior weight, strength and family mask; the user must
// do so only while idle, as the block itself does not enforce it. After reset
// the block clears every family table, one entry per cycle in all lanes at
// once, with req_tready low meanwhile. A request passes through one table
// read, the entry update, 64 steps of the per-lane divider, the merge
// stage's term sum, a 70-step divide by the hit count and the multiply and
// scaling by strength; with no contributing family the merge divide and
// scaling are skipped. One item is in flight, and the next word can be
// accepted in the cycle after the result is loaded into the output register.
// The result sits in an output register; a new word is accepted while it
// waits, and a finished item waits for the register if the receiver stalls.
// ----------------------------------------------------------------------------
module hashed_residual_sse_refiner import ssr_pkg::*; #(
   parameter int TBL_BITS     = TBL_BITS_DEF,
   parameter int FAMILY_COUNT = FAMILY_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // base_probability, coded_bit, index_0 .. index_9, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // refined_probability, contributing_families, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_MERGE = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [TBL_BITS-1:0]   clr_ff, clr_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic [PRIOR_W-1:0]    prior_ff;
   logic [STRENGTH_W-1:0] strength_ff;
   logic [MASK_W-1:0]     mask_ff;
   logic [PROB_W-1:0]     base_ff;
   logic                  bit_ff;
   logic [TBL_BITS-1:0]   idx_ff [FAMILY_COUNT];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]     rsp_prob_ff;
   logic [USED_W-1:0]     rsp_used_ff;

   ssr_lane_ctl_type      lane_ctl;
   logic [SUM_W-1:0]      term_mag [FAMILY_COUNT];
   logic                  term_neg [FAMILY_COUNT];
   logic                  term_hit [FAMILY_COUNT];
   logic                  merge_done;
   logic [PROB_W-1:0]     merge_prob;
   logic [USED_W-1:0]     merge_used;
   logic                  accept;
   logic                  out_load;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + TBL_BITS'(1);
            if (clr_ff == {TBL_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(SUM_W - 1)) begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            if (merge_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      lane_ctl.clear = (state_ff == S_CLEAR);
      lane_ctl.load  = (state_ff == S_UPD);
      lane_ctl.step  = (state_ff == S_DIV);
      rsp_valid_in   = out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         prior_ff     <= PRIOR_RESET;
         strength_ff  <= STRENGTH_RESET;
         mask_ff      <= MASK_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PRIOR:    prior_ff    <= csr_wdata[PRIOR_W-1:0];
               CSR_STRENGTH: strength_ff <= csr_wdata;
               CSR_MASK:     mask_ff     <= csr_wdata[MASK_W-1:0];
               default: begin
               end
            endcase
         end
      end
      cnt_ff <= cnt_in;
      if (accept) begin
         base_ff <= req_tdata[PROB_W-1:0];
         bit_ff  <= req_tdata[PROB_W];
      end
      if (out_load) begin
         rsp_prob_ff <= merge_prob;
         rsp_used_ff <= merge_used;
      end
   end

   genvar f;
   generate
      for (f = 0; f < FAMILY_COUNT; f++) begin : g_lane
         logic [INDEX_W+TBL_BITS-1:0] idx_ext;

         // Only the low TBL_BITS bits of an index select the entry.
         assign idx_ext = {{TBL_BITS{1'b0}},
                           req_tdata[PROB_W+1+f*INDEX_W +: INDEX_W]};

         always_ff @(posedge clock) begin
            if (accept) begin
               idx_ff[f] <= idx_ext[TBL_BITS-1:0];
            end
         end

         ssr_lane #(
            .TBL_BITS(TBL_BITS)
         ) u_lane (
            .clock        (clock),
            .reset        (reset),
            .ctl          (lane_ctl),
            .clr_addr     (clr_ff),
            .addr         (idx_ff[f]),
            .enable       (mask_ff[f]),
            .prior_weight (prior_ff),
            .base         (base_ff),
            .coded_bit    (bit_ff),
            .term_mag     (term_mag[f]),
            .term_neg     (term_neg[f]),
            .term_hit     (term_hit[f])
         );
      end
   endgenerate

   ssr_merge #(
      .FAMILY_COUNT(FAMILY_COUNT)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .start        ((state_ff == S_DIV) && (cnt_ff == 7'(SUM_W - 1))),
      .term_mag     (term_mag),
      .term_neg     (term_neg),
      .term_hit     (term_hit),
      .base         (base_ff),
      .strength     (strength_ff),
      .done         (merge_done),
      .refined      (merge_prob),
      .used         (merge_used)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PROB_W-USED_W){1'b0}}, rsp_used_ff, rsp_prob_ff};

endmodule

[hw/rtl/ssr_ram.sv]
// ----------------------------------------------------------------------------
// ssr_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ssr_lane.sv]
// ----------------------------------------------------------------------------
// ssr_lane
// One hash family: its table, the entry update and a bit-serial divider
// that forms the magnitude of sum / (count + prior).
// ----------------------------------------------------------------------------
module ssr_lane import ssr_pkg::*; #(
   parameter int TBL_BITS = TBL_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ssr_lane_ctl_type       ctl,
   input  logic [TBL_BITS-1:0]    clr_addr,
   input  logic [TBL_BITS-1:0]    addr,
   input  logic                   enable,
   input  logic [PRIOR_W-1:0]     prior_weight,
   input  logic [PROB_W-1:0]      base,
   input  logic                   coded_bit,
   output logic [SUM_W-1:0]       term_mag,
   output logic                   term_neg,
   output logic                   term_hit
);

   localparam int ENTRY_W = SUM_W + COUNT_W;

   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;
   logic [COUNT_W-1:0] cnt;
   logic [SUM_W-1:0]   sum;
   logic [COUNT_W-1:0] cnt_new;
   logic [SUM_W-1:0]   sum_new;
   logic [SUM_W-1:0]   delta;

   logic [SUM_W-1:0]   q_ff, q_in;
   logic [COUNT_W:0]   rem_ff, rem_in;
   logic [COUNT_W:0]   div_ff, div_in;
   logic               neg_ff, neg_in;
   logic               hit_ff, hit_in;
   logic [COUNT_W+1:0] r_sh;

   assign cnt = rd_data[COUNT_W-1:0];
   assign sum = rd_data[ENTRY_W-1:COUNT_W];

   always_comb begin
      if (coded_bit) begin
         delta = SUM_W'(PROB_ONE - {1'b0, base});
      end else begin
         delta = SUM_W'(0) - SUM_W'(base);
      end
      cnt_new = (cnt == {COUNT_W{1'b1}}) ? cnt : cnt + COUNT_W'(1);
      sum_new = sum + delta;
      wr_data = ctl.clear ? '0 : {sum_new, cnt_new};
   end

   ssr_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(1 << TBL_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ctl.clear | (ctl.load & enable)),
      .wr_addr (ctl.clear ? clr_addr : addr),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // Restoring division, one quotient bit per step.
   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      hit_in = hit_ff;
      r_sh   = {rem_ff, q_ff[SUM_W-1]};
      if (ctl.load) begin
         hit_in = enable && (cnt != '0);
         neg_in = sum[SUM_W-1];
         q_in   = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
         rem_in = '0;
         div_in = {1'b0, cnt} + (COUNT_W+1)'(prior_weight);
      end else if (ctl.step) begin
         if (r_sh >= {1'b0, div_ff}) begin
            rem_in = (COUNT_W+1)'(r_sh - {1'b0, div_ff});
            q_in   = {q_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = r_sh[COUNT_W:0];
            q_in   = {q_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign term_mag = q_ff;
   assign term_neg = neg_ff;
   assign term_hit = hit_ff;

endmodule

[hw/rtl/ssr_merge.sv]
// ----------------------------------------------------------------------------
// ssr_merge
// Combines the lane terms: sums them, divides by the number of hits, scales by
// strength in parts per million, adds the signed result to base and clamps it.
// ----------------------------------------------------------------------------
module ssr_merge import ssr_pkg::*; #(
   parameter int FAMILY_COUNT = FAMILY_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SUM_W-1:0]      term_mag [FAMILY_COUNT],
   input  logic                  term_neg [FAMILY_COUNT],
   input  logic                  term_hit [FAMILY_COUNT],
   input  logic [PROB_W-1:0]     base,
   input  logic [STRENGTH_W-1:0] strength,
   output logic                  done,
   output logic [PROB_W-1:0]     refined,
   output logic [USED_W-1:0]     used
);

   localparam int KW     = (FAMILY_COUNT > 1) ? $clog2(FAMILY_COUNT) : 1;
   localparam int STEP_W = $clog2(ACC_W + 1);
   localparam int PROD_W = 41 + STRENGTH_W;

   // Any scaled value of 65536 or more clamps the same way, so larger
   // products are saturated before the division by one million.
   localparam logic [36:0] SAT_LIMIT = 37'(PROB_ONE) * 37'(PPM_SCALE);
   // Rounded-up 2^44 / 15625; exact quotient for dividends below 2^30.
   localparam logic [30:0] RECIP_M   = 31'd1125899907;

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_ACC   = 3'd1;
   localparam logic [2:0] M_MEAN  = 3'd2;
   localparam logic [2:0] M_MUL   = 3'd3;
   localparam logic [2:0] M_SCALE = 3'd4;
   localparam logic [2:0] M_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic                  neg_ff, neg_in;
   logic [ACC_W-1:0]      q_ff, q_in;
   logic [STRENGTH_W-1:0] rem_ff, rem_in;
   logic [STRENGTH_W-1:0] dvs_ff, dvs_in;
   logic [PROB_W-1:0]     res_ff, res_in;
   logic [STRENGTH_W:0]   r_sh;
   logic [ACC_W-1:0]      term_ext;
   logic [40:0]           mean_sat;
   logic [PROD_W-1:0]     product;
   logic [60:0]           recip;
   logic [16:0]           scaled;
   logic signed [43:0]    total;

   always_comb begin
      term_ext = ACC_W'(term_mag[k_ff]);
      r_sh     = {rem_ff, q_ff[ACC_W-1]};
      if ((q_ff[ACC_W-1:41] != '0) || (q_ff[40:0] > {1'b1, 40'd0})) begin
         mean_sat = {1'b1, 40'd0};
      end else begin
         mean_sat = q_ff[40:0];
      end
      product = PROD_W'(mean_sat) * PROD_W'(strength);
      // Dividing by one million is a shift by six and a division by 15625.
      recip = {31'b0, q_ff[35:6]} * {30'b0, RECIP_M};
      if (q_ff >= ACC_W'(SAT_LIMIT)) begin
         scaled = 17'h10000;
      end else begin
         scaled = {1'b0, recip[59:44]};
      end
      if (neg_ff) begin
         total = 44'(signed'({1'b0, base})) - signed'({2'b00, q_ff[41:0]});
      end else begin
         total = 44'(signed'({1'b0, base})) + signed'({2'b00, q_ff[41:0]});
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      used_in  = used_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      res_in   = res_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               k_in     = '0;
               acc_in   = '0;
               used_in  = '0;
               state_in = M_ACC;
            end
         end
         M_ACC: begin
            if (term_hit[k_ff]) begin
               acc_in  = term_neg[k_ff] ? acc_ff - term_ext : acc_ff + term_ext;
               used_in = used_ff + USED_W'(1);
            end
            k_in = k_ff + KW'(1);
            if (k_ff == KW'(FAMILY_COUNT - 1)) begin
               state_in = M_MEAN;
               step_in  = '0;
               rem_in   = '0;
            end
         end
         M_MEAN: begin
            if (step_ff == '0) begin
               // The first step loads the dividend magnitude and the divisor; with no hits it ends here.
               neg_in  = acc_ff[ACC_W-1];
               q_in    = acc_ff[ACC_W-1] ? ACC_W'(0) - acc_ff : acc_ff;
               dvs_in  = STRENGTH_W'(used_ff);
               step_in = STEP_W'(1);
               if (used_ff == '0) begin
                  res_in   = base;
                  state_in = M_DONE;
               end
            end else begin
               if (r_sh >= {1'b0, dvs_ff}) begin
                  rem_in = STRENGTH_W'(r_sh - {1'b0, dvs_ff});
                  q_in   = {q_ff[ACC_W-2:0], 1'b1};
               end else begin
                  rem_in = r_sh[STRENGTH_W-1:0];
                  q_in   = {q_ff[ACC_W-2:0], 1'b0};
               end
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(ACC_W)) begin
                  state_in = M_MUL;
               end
            end
         end
         M_MUL: begin
            q_in     = ACC_W'(product);
            state_in = M_SCALE;
         end
         M_SCALE: begin
            q_in     = ACC_W'(scaled);
            state_in = M_DONE;
            res_in   = '0;
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff    <= k_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      used_ff <= used_in;
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      res_ff  <= res_in;
   end

   // With hits, the output is the base plus the signed scaled quotient, clamped to 1 .. 65535.
   always_comb begin
      if (used_ff == '0) begin
         refined = res_ff;
      end else if (total < 44'sd1) begin
         refined = PROB_W'(1);
      end else if (total > 44'sd65535) begin
         refined = {PROB_W{1'b1}};
      end else begin
         refined = total[PROB_W-1:0];
      end
   end

   assign done = (state_ff == M_DONE);
   assign used = used_ff;

endmodule
